// ----- rtl/tvp_pkg.sv -----
// Shared types, constants and helpers for the trapezoidal velocity profile block.
package tvp_pkg;

    localparam int unsigned QUANTUM_RESET = 327;
    localparam int unsigned SEC_PER_MIN   = 60;
    localparam int unsigned MUL_STEPS     = 34;
    localparam int unsigned DIV_STEPS     = 64;
    localparam int unsigned SQRT_STEPS    = 32;
    localparam int unsigned CNT_W         = 7;

    localparam logic        OP_PLAN          = 1'b0;
    localparam logic        OP_EVAL          = 1'b1;
    localparam logic        REG_TIME_QUANTUM = 1'b0;
    localparam logic [16:0] PROGRESS_FULL    = 17'd65536;

    typedef struct packed {
        logic               operation;
        logic        [31:0] path_length;
        logic        [31:0] nominal_feed;
        logic        [31:0] accel_limit;
        logic signed [31:0] eval_time;
    } t_in;

    typedef struct packed {
        logic [16:0] progress;
        logic [31:0] speed;
        logic [31:0] duration;
    } t_out;

    typedef enum logic [1:0] {
        AOP_MUL,
        AOP_DIV,
        AOP_SQRT
    } t_arith_op;

    typedef struct packed {
        logic        start;
        t_arith_op   op;
        logic [63:0] a;
        logic [33:0] b;
    } t_arith_req;

    typedef struct packed {
        logic        done;
        logic [81:0] res;
    } t_arith_rsp;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PLAN_FM,
        ST_PLAN_UP,
        ST_PLAN_LS,
        ST_TRI_X,
        ST_TRI_SQRT,
        ST_DIVQ,
        ST_MULQ,
        ST_PEAK,
        ST_RATE_UP,
        ST_RATE_DOWN,
        ST_EVAL_UPV,
        ST_EVAL_UPD,
        ST_EVAL_CRU,
        ST_EVAL_LIN,
        ST_EVAL_W,
        ST_EVAL_QUAD,
        ST_EVAL_PROG,
        ST_EVAL_SPD,
        ST_EMIT
    } t_state;

    function automatic logic [31:0] sat32(input logic [81:0] x);
        return (|x[81:32]) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

endpackage

// ----- rtl/tvp_arith.sv -----
// Shared bit-serial arithmetic unit: multiply, divide and square root, one bit per cycle.
module tvp_arith import tvp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_arith_req i_req,
    output t_arith_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    t_arith_op        r_op;
    logic [CNT_W-1:0] r_cnt;
    logic [47:0]      r_a;
    logic [33:0]      r_dv;
    logic [63:0]      r_dq;
    logic [34:0]      r_rem;
    logic [31:0]      r_root;
    logic [81:0]      r_prod;

    logic [CNT_W-1:0] w_last;
    logic [48:0]      w_mul_sum;
    logic [34:0]      w_div_trial;
    logic [34:0]      w_div_diff;
    logic             w_div_ge;
    logic [34:0]      w_sq_rem;
    logic [34:0]      w_sq_trial;
    logic             w_sq_ge;

    always_comb begin
        case (r_op)
            AOP_MUL:  w_last = CNT_W'(MUL_STEPS - 1);
            AOP_DIV:  w_last = CNT_W'(DIV_STEPS - 1);
            AOP_SQRT: w_last = CNT_W'(SQRT_STEPS - 1);
            default:  w_last = CNT_W'(DIV_STEPS - 1);
        endcase
    end

    assign w_mul_sum   = {1'b0, r_prod[81:34]} + {1'b0, r_a};
    assign w_div_trial = {r_rem[33:0], r_dq[63]};
    assign w_div_diff  = w_div_trial - {1'b0, r_dv};
    assign w_div_ge    = w_div_trial >= {1'b0, r_dv};
    assign w_sq_rem    = {r_rem[32:0], r_dq[63:62]};
    assign w_sq_trial  = {1'b0, r_root, 2'b01};
    assign w_sq_ge     = w_sq_rem >= w_sq_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= AOP_DIV;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_op   <= i_req.op;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a    <= i_req.a[47:0];
            r_prod <= {48'd0, i_req.b};
            r_dq   <= i_req.a;
            r_dv   <= i_req.b;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            case (r_op)
                AOP_MUL: begin
                    // Shift-add, multiplier bits consumed from the bottom.
                    r_prod <= r_prod[0] ? {w_mul_sum, r_prod[33:1]} : {1'b0, r_prod[81:1]};
                end
                AOP_DIV: begin
                    r_rem <= w_div_ge ? {1'b0, w_div_diff[33:0]} : {1'b0, w_div_trial[33:0]};
                    r_dq  <= {r_dq[62:0], w_div_ge};
                end
                AOP_SQRT: begin
                    r_rem  <= w_sq_ge ? (w_sq_rem - w_sq_trial) : w_sq_rem;
                    r_root <= {r_root[30:0], w_sq_ge};
                    r_dq   <= {r_dq[61:0], 2'b00};
                end
                default: begin
                    r_rem <= r_rem;
                end
            endcase
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        case (r_op)
            AOP_MUL:  o_rsp.res = r_prod;
            AOP_DIV:  o_rsp.res = {18'd0, r_dq};
            AOP_SQRT: o_rsp.res = {50'd0, r_root};
            default:  o_rsp.res = {18'd0, r_dq};
        endcase
    end

endmodule

// ----- rtl/trapezoidal_velocity_profile.sv -----
// Trapezoidal velocity profile generator: planning and evaluation sequencer.
//
// Input words (i_in_valid / o_in_stall) either plan a move (operation 0:
// length, feed in mm/min, acceleration) or evaluate the planned profile at a
// signed time (operation 1). Every input word gives exactly one output word
// (o_out_valid / i_out_stall) carrying progress (Q1.16), speed (mm/min) and
// the quantized move duration. All multiplies, divides and square roots
// run through one shared bit-serial unit that retires one bit per cycle.
// A triangular plan adds a divide and a square root to the steps of a
// trapezoid. An evaluation before the start, after the end, or with no
// move planned skips the arithmetic unit.
// One word is worked on at a time; o_in_stall is high from acceptance until
// the result is loaded into the output register. A finished result waiting on
// a stalled receiver holds its word stable, and the next input word can still
// be accepted and worked on meanwhile.
// time_quantum sits at byte address 0 of the APB port and should only be
// written while the block is idle. Reset clears the profile to zero and sets
// the quantum to 327 raw units.
module trapezoidal_velocity_profile import tvp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in         i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out        o_out_data,
    input  logic        i_out_stall,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_state      r_state, n_state;
    logic        r_issued;
    logic        r_tri;
    logic [31:0] r_time_quantum;
    logic [31:0] r_ramp_up_time, r_cruise_time, r_ramp_down_time;
    logic [31:0] r_ramp_up_rate, r_ramp_down_rate;
    logic [31:0] r_peak_speed, r_move_length, r_move_time;
    logic [31:0] r_len, r_feed, r_accl, r_t;
    logic [31:0] r_fm, r_up, r_q, r_v;
    logic [63:0] r_x;
    logic [47:0] r_w;
    logic [16:0] r_res_prog;
    logic [31:0] r_res_spd;
    logic        r_out_valid;
    t_out        r_out;

    t_arith_req  w_req;
    t_arith_rsp  w_rsp;

    logic        w_accept, w_emit_load, w_cfg_wr;
    logic        w_uses_engine, w_skip, w_step_done;
    logic [31:0] w_tq, w_in_t;
    logic        w_in_deg, w_ev_zero, w_ev_end;
    logic [32:0] w_t2;
    logic [33:0] w_t3;
    logic [32:0] w_up2;
    logic [31:0] w_up2_sat;
    logic [32:0] w_cr_diff;
    logic [31:0] w_cruise;
    logic [32:0] w_trap_den;
    logic [32:0] w_tri_down_full;
    logic [31:0] w_tri_down;
    logic [32:0] w_tri_den;
    logic [32:0] w_den;
    logic [31:0] w_down;
    logic [63:0] w_peak_dvd;
    logic        w_ls_gt;
    logic [32:0] w_q1;
    logic [32:0] w_u_full;
    logic [31:0] w_u;
    logic [32:0] w_cru_a;
    logic [32:0] w_cu;
    logic [33:0] w_lin_a;
    logic [64:0] w_quad;
    logic [31:0] w_dist;

    tvp_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_emit_load = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TIME_QUANTUM);
    assign prdata   = (paddr[2] == REG_TIME_QUANTUM) ? r_time_quantum : 32'd0;

    // A zero quantum is treated as one raw unit.
    assign w_tq = (r_time_quantum == 32'd0) ? 32'd1 : r_time_quantum;

    assign w_in_t    = i_in_data.eval_time;
    assign w_in_deg  = (i_in_data.path_length == 32'd0) || (i_in_data.accel_limit == 32'd0)
                       || (i_in_data.nominal_feed < 32'(SEC_PER_MIN));
    assign w_t2      = {1'b0, r_ramp_up_time} + {1'b0, r_cruise_time};
    assign w_t3      = {1'b0, w_t2} + {2'b0, r_ramp_down_time};
    assign w_ev_zero = (r_move_length == 32'd0) || w_in_t[31];
    assign w_ev_end  = {2'b0, w_in_t} >= w_t3;

    // Plan-side helpers.
    assign w_up2      = {r_up, 1'b0};
    assign w_up2_sat  = r_up[31] ? 32'hFFFF_FFFF : {r_up[30:0], 1'b0};
    assign w_cr_diff  = {1'b0, r_q} - w_up2;
    assign w_cruise   = ({1'b0, r_q} > w_up2) ? w_cr_diff[31:0] : 32'd0;
    assign w_trap_den = {1'b0, r_up} + {1'b0, w_cruise};
    assign w_tri_down_full = {1'b0, r_up} + {1'b0, r_q - w_up2_sat};
    assign w_tri_down = w_tri_down_full[32] ? 32'hFFFF_FFFF : w_tri_down_full[31:0];
    assign w_tri_den  = {1'b0, r_up} + {1'b0, w_tri_down};
    assign w_den      = r_tri ? w_tri_den : w_trap_den;
    assign w_down     = r_tri ? w_tri_down : r_up;
    assign w_peak_dvd = r_tri ? {15'd0, r_len, 17'd0} : {16'd0, r_len, 16'd0};
    assign w_ls_gt    = w_rsp.res[63:0] > {32'd0, r_up};
    assign w_q1       = {1'b0, r_x[31:0]} + 33'd1;

    // Evaluate-side helpers.
    assign w_u_full = {1'b0, r_t} - w_t2;
    assign w_u      = w_u_full[31:0];
    assign w_cru_a  = {r_t, 1'b0} - {1'b0, r_ramp_up_time};
    assign w_cu     = {1'b0, r_cruise_time} + {1'b0, w_u};
    assign w_lin_a  = {w_cu, 1'b0} + {2'b0, r_ramp_up_time};
    assign w_quad   = w_rsp.res[81:17];
    assign w_dist   = (r_x > {32'd0, r_move_length}) ? r_move_length : r_x[31:0];

    always_comb begin
        case (r_state)
            ST_PEAK:      w_skip = (w_den == 33'd0);
            ST_RATE_UP:   w_skip = (r_ramp_up_time == 32'd0);
            ST_RATE_DOWN: w_skip = (r_ramp_down_time == 32'd0);
            default:      w_skip = 1'b0;
        endcase
    end

    assign w_uses_engine = (r_state != ST_IDLE) && (r_state != ST_EMIT);
    assign w_step_done   = w_skip || (r_issued && w_rsp.done);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.operation == OP_PLAN) begin
                        n_state = w_in_deg ? ST_EMIT : ST_PLAN_FM;
                    end else if (w_ev_zero || w_ev_end) begin
                        n_state = ST_EMIT;
                    end else if (w_in_t < r_ramp_up_time) begin
                        n_state = ST_EVAL_UPV;
                    end else if ({1'b0, w_in_t} < w_t2) begin
                        n_state = ST_EVAL_CRU;
                    end else begin
                        n_state = ST_EVAL_LIN;
                    end
                end
            end
            ST_PLAN_FM:   if (w_step_done) n_state = ST_PLAN_UP;
            ST_PLAN_UP:   if (w_step_done) n_state = ST_PLAN_LS;
            ST_PLAN_LS:   if (w_step_done) n_state = w_ls_gt ? ST_DIVQ : ST_TRI_X;
            ST_TRI_X:     if (w_step_done) n_state = ST_TRI_SQRT;
            ST_TRI_SQRT:  if (w_step_done) n_state = ST_DIVQ;
            ST_DIVQ:      if (w_step_done) n_state = ST_MULQ;
            ST_MULQ:      if (w_step_done) n_state = ST_PEAK;
            ST_PEAK:      if (w_step_done) n_state = ST_RATE_UP;
            ST_RATE_UP:   if (w_step_done) n_state = ST_RATE_DOWN;
            ST_RATE_DOWN: if (w_step_done) n_state = ST_EMIT;
            ST_EVAL_UPV:  if (w_step_done) n_state = ST_EVAL_UPD;
            ST_EVAL_UPD:  if (w_step_done) n_state = ST_EVAL_PROG;
            ST_EVAL_CRU:  if (w_step_done) n_state = ST_EVAL_PROG;
            ST_EVAL_LIN:  if (w_step_done) n_state = ST_EVAL_W;
            ST_EVAL_W:    if (w_step_done) n_state = ST_EVAL_QUAD;
            ST_EVAL_QUAD: if (w_step_done) n_state = ST_EVAL_PROG;
            ST_EVAL_PROG: if (w_step_done) n_state = ST_EVAL_SPD;
            ST_EVAL_SPD:  if (w_step_done) n_state = ST_EMIT;
            ST_EMIT:      if (w_emit_load) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Requests to the arithmetic unit.
    always_comb begin
        w_req.start = w_uses_engine && !r_issued && !w_skip;
        w_req.op    = AOP_DIV;
        w_req.a     = '0;
        w_req.b     = '0;
        case (r_state)
            ST_PLAN_FM: begin
                w_req.a = {32'd0, r_feed};
                w_req.b = 34'(SEC_PER_MIN);
            end
            ST_PLAN_UP: begin
                w_req.a = {16'd0, r_fm, 16'd0};
                w_req.b = {2'b0, r_accl};
            end
            ST_PLAN_LS: begin
                w_req.a = {16'd0, r_len, 16'd0};
                w_req.b = {2'b0, r_fm};
            end
            ST_TRI_X: begin
                w_req.a = {16'd0, r_len, 16'd0};
                w_req.b = {2'b0, r_accl};
            end
            ST_TRI_SQRT: begin
                w_req.op = AOP_SQRT;
                w_req.a  = {r_x[47:0], 16'd0};
            end
            ST_DIVQ: begin
                w_req.a = {32'd0, (r_tri ? w_up2_sat : r_x[31:0])};
                w_req.b = {2'b0, w_tq};
            end
            ST_MULQ: begin
                w_req.op = AOP_MUL;
                w_req.a  = {31'd0, w_q1};
                w_req.b  = {2'b0, w_tq};
            end
            ST_PEAK: begin
                w_req.a = w_peak_dvd;
                w_req.b = {1'b0, w_den};
            end
            ST_RATE_UP: begin
                w_req.a = {16'd0, r_peak_speed, 16'd0};
                w_req.b = {2'b0, r_ramp_up_time};
            end
            ST_RATE_DOWN: begin
                w_req.a = {16'd0, r_peak_speed, 16'd0};
                w_req.b = {2'b0, r_ramp_down_time};
            end
            ST_EVAL_UPV: begin
                w_req.op = AOP_MUL;
                w_req.a  = {32'd0, r_ramp_up_rate};
                w_req.b  = {2'b0, r_t};
            end
            ST_EVAL_UPD: begin
                w_req.op = AOP_MUL;
                w_req.a  = {32'd0, r_v};
                w_req.b  = {2'b0, r_t};
            end
            ST_EVAL_CRU: begin
                w_req.op = AOP_MUL;
                w_req.a  = {31'd0, w_cru_a};
                w_req.b  = {2'b0, r_peak_speed};
            end
            ST_EVAL_LIN: begin
                w_req.op = AOP_MUL;
                w_req.a  = {30'd0, w_lin_a};
                w_req.b  = {2'b0, r_peak_speed};
            end
            ST_EVAL_W: begin
                w_req.op = AOP_MUL;
                w_req.a  = {32'd0, r_ramp_down_rate};
                w_req.b  = {2'b0, w_u};
            end
            ST_EVAL_QUAD: begin
                w_req.op = AOP_MUL;
                w_req.a  = {16'd0, r_w};
                w_req.b  = {2'b0, w_u};
            end
            ST_EVAL_PROG: begin
                w_req.a = {16'd0, w_dist, 16'd0};
                w_req.b = {2'b0, r_move_length};
            end
            ST_EVAL_SPD: begin
                w_req.op = AOP_MUL;
                w_req.a  = {32'd0, r_v};
                w_req.b  = 34'(SEC_PER_MIN);
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    // Control state, configuration and the planned profile.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_issued         <= 1'b0;
            r_out_valid      <= 1'b0;
            r_time_quantum   <= 32'(QUANTUM_RESET);
            r_ramp_up_time   <= '0;
            r_cruise_time    <= '0;
            r_ramp_down_time <= '0;
            r_ramp_up_rate   <= '0;
            r_ramp_down_rate <= '0;
            r_peak_speed     <= '0;
            r_move_length    <= '0;
            r_move_time      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= w_emit_load || (r_out_valid && i_out_stall);
            if (w_req.start) begin
                r_issued <= 1'b1;
            end else if (w_rsp.done) begin
                r_issued <= 1'b0;
            end
            if (w_cfg_wr) begin
                r_time_quantum <= pwdata;
            end
            if (w_accept && i_in_data.operation == OP_PLAN && w_in_deg) begin
                r_ramp_up_time   <= '0;
                r_cruise_time    <= '0;
                r_ramp_down_time <= '0;
                r_ramp_up_rate   <= '0;
                r_ramp_down_rate <= '0;
                r_peak_speed     <= '0;
                r_move_length    <= '0;
                r_move_time      <= '0;
            end
            if (r_state == ST_PEAK && w_step_done) begin
                r_ramp_up_time   <= r_up;
                r_cruise_time    <= r_tri ? 32'd0 : w_cruise;
                r_ramp_down_time <= w_down;
                r_peak_speed     <= w_skip ? 32'd0 : sat32(w_rsp.res);
                r_move_length    <= r_len;
                r_move_time      <= r_q;
            end
            if (r_state == ST_RATE_UP && w_step_done) begin
                r_ramp_up_rate <= w_skip ? 32'd0 : sat32(w_rsp.res);
            end
            if (r_state == ST_RATE_DOWN && w_step_done) begin
                r_ramp_down_rate <= w_skip ? 32'd0 : sat32(w_rsp.res);
            end
        end
    end

    // Working registers of the sequence.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_len      <= i_in_data.path_length;
            r_feed     <= i_in_data.nominal_feed;
            r_accl     <= i_in_data.accel_limit;
            r_t        <= w_in_t;
            r_res_spd  <= '0;
            r_res_prog <= (i_in_data.operation == OP_EVAL && !w_ev_zero && w_ev_end)
                          ? PROGRESS_FULL : 17'd0;
        end
        if (w_step_done) begin
            case (r_state)
                ST_PLAN_FM:  r_fm <= w_rsp.res[31:0];
                ST_PLAN_UP:  r_up <= sat32(w_rsp.res);
                ST_PLAN_LS: begin
                    r_tri <= !w_ls_gt;
                    r_x   <= {32'd0, sat32(w_rsp.res + 82'(r_up))};
                end
                ST_TRI_X:    r_x  <= w_rsp.res[63:0];
                ST_TRI_SQRT: r_up <= w_rsp.res[31:0];
                ST_DIVQ:     r_x  <= w_rsp.res[63:0];
                ST_MULQ:     r_q  <= sat32(w_rsp.res);
                ST_EVAL_UPV: r_v  <= sat32({16'd0, w_rsp.res[81:16]});
                ST_EVAL_UPD: r_x  <= w_rsp.res[80:17];
                ST_EVAL_CRU: begin
                    r_x <= w_rsp.res[80:17];
                    r_v <= r_peak_speed;
                end
                ST_EVAL_LIN: r_x  <= w_rsp.res[80:17];
                ST_EVAL_W:   r_w  <= w_rsp.res[63:16];
                ST_EVAL_QUAD: begin
                    r_x <= ({1'b0, r_x} > w_quad) ? (r_x - w_quad[63:0]) : 64'd0;
                    r_v <= (r_w < {16'd0, r_peak_speed}) ? (r_peak_speed - r_w[31:0]) : 32'd0;
                end
                ST_EVAL_PROG: r_res_prog <= w_rsp.res[16:0];
                ST_EVAL_SPD:  r_res_spd  <= sat32(w_rsp.res);
                default: begin
                    r_x <= r_x;
                end
            endcase
        end
        if (w_emit_load) begin
            r_out.progress <= r_res_prog;
            r_out.speed    <= r_res_spd;
            r_out.duration <= r_move_time;
        end
    end

endmodule

// ----- rtl/tvp_checker.sv -----
// Port-level checks for the trapezoidal velocity profile block, bound to the top level.
module tvp_checker import tvp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input t_out        o_out_data,
    input logic        i_out_stall
);

    // A waiting result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    // A waiting result does not change.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("stalled result word changed");

    // The block works on one word at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word accepted while busy");

    // Progress never passes the full path.
    a_progress_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.progress <= PROGRESS_FULL))
        else $error("progress beyond full path");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

endmodule

bind trapezoidal_velocity_profile tvp_checker u_tvp_checker (.*);
